// ===== rtl/core/ecp_pkg.sv =====
`timescale 1ns / 1ps

package ecp_pkg;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 144;

  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_LFU = 2'd1;
  localparam logic [1:0] POL_TTL = 2'd2;

  localparam logic [9:0] LRU_CLOCK_RES   = 10'd1000;
  localparam logic [7:0] LFU_COUNTER_MAX = 8'd255;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCORE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_BEST_RD,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/ecp_score_unit.sv =====
`timescale 1ns / 1ps

module ecp_score_unit #(
  parameter int CLOCK_BITS = 24
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [1:0]            policy,
  input  logic [CLOCK_BITS-1:0] now_clock,
  input  logic [63:0]           sample_value,
  output logic [63:0]           score,
  output logic                  usable
);

  logic [CLOCK_BITS-1:0] stamp;
  logic [CLOCK_BITS-1:0] age;
  logic [63:0]           score_nxt;
  logic                  usable_nxt;
  logic [63:0]           score_r;
  logic                  usable_r;

  assign stamp = sample_value[CLOCK_BITS-1:0];

  // wrapped difference; the wrap path loses one tick
  always_comb begin
    age = now_clock - stamp;
    if (now_clock < stamp) begin
      age = age - CLOCK_BITS'(1);
    end
  end

  always_comb begin
    score_nxt  = '0;
    usable_nxt = 1'b1;
    case (policy)
      ecp_pkg::POL_LRU: score_nxt = 64'(age) * 64'(ecp_pkg::LRU_CLOCK_RES);
      ecp_pkg::POL_LFU: begin
        if (sample_value > 64'(ecp_pkg::LFU_COUNTER_MAX)) begin
          score_nxt = '0;
        end else begin
          score_nxt = 64'(ecp_pkg::LFU_COUNTER_MAX) - sample_value;
        end
      end
      ecp_pkg::POL_TTL: score_nxt = ~sample_value;
      default:          usable_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score_r  <= score_nxt;
      usable_r <= usable_nxt;
    end
  end

  assign score  = score_r;
  assign usable = usable_r;

endmodule

// ===== rtl/core/eviction_candidate_pool_unit.sv =====
`timescale 1ns / 1ps

// Sorted eviction candidate pool. Each request carries one sampled key; its
// eviction score (LRU age x 1000, 255 - LFU counter, or ~expire time) is
// inserted into a pool of POOL_DEPTH entries kept in ascending order, and one
// result reports the slot, any displaced key, the fill level and the current
// best candidate. The pool lives in a single-port memory served by one score
// comparator and one copy path under a sequencer, one request at a time:
// an item whose policy code is unused skips the scan, a dropped sample is
// scanned but not stored, and otherwise the scan is followed by any shift of
// entries and then the insert, plus any wait for the output register. A
// finished result is held in an output register, so the next request is
// taken while it waits. No clearing pass after reset.
module eviction_candidate_pool_unit #(
  parameter int POOL_DEPTH = 16,
  parameter int CLOCK_BITS = 24,
  parameter int KEY_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // key_handle[31:0], db_number[35:32], now_clock[59:36], sample_value[123:60]
  input  logic [ecp_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // accepted[0], slot[4:1], displaced_valid[5], displaced_key[37:6],
  // fill_level[42:38], best_key[74:43], best_db[78:75], best_score[142:79]
  output logic [ecp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int WW = 64 + KEY_BITS + 4;

  logic [WW-1:0] mem [POOL_DEPTH];
  logic [WW-1:0] rdata_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [WW-1:0] wdata;

  ecp_pkg::state_t state_r, state_nxt;
  logic [1:0]          policy_r;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic [IW-1:0]       ptr_r, ptr_nxt;
  logic                left_r, left_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [3:0]          db_r, db_nxt;
  logic [KEY_BITS-1:0] key0_r, key0_nxt;
  logic [KEY_BITS-1:0] dkey_r, dkey_nxt;
  logic                dvalid_r, dvalid_nxt;
  logic                acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ecp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic          in_acc;
  logic [63:0]   score;
  logic          usable;
  logic          full;
  logic          lt;
  logic [CW-1:0] idx_inc;
  logic          scan_done;
  logic [CW-1:0] k_w;
  logic          drop;
  logic [IW-1:0] ptr_adj;
  logic          shift_last;
  logic          out_free;
  logic [KEY_BITS-1:0] rd_key;
  logic [3:0]          rd_db;
  logic [63:0]         rd_score;

  assign in_tready = (state_r == ecp_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  ecp_score_unit #(
    .CLOCK_BITS(CLOCK_BITS)
  ) u_score (
    .clk         (clk),
    .en          (in_acc),
    .policy      (policy_r),
    .now_clock   (CLOCK_BITS'(in_tdata[59:36])),
    .sample_value(in_tdata[123:60]),
    .score       (score),
    .usable      (usable)
  );

  assign rd_score = rdata_r[63:0];
  assign rd_key   = rdata_r[64 +: KEY_BITS];
  assign rd_db    = rdata_r[WW-1 -: 4];

  assign full       = (fill_r == CW'(POOL_DEPTH));
  assign lt         = (rd_score < score);
  assign idx_inc    = idx_r + CW'(1);
  assign scan_done  = !lt || (idx_inc == fill_r);
  assign k_w        = lt ? fill_r : idx_r;
  assign drop       = full && (k_w == '0);
  assign ptr_adj    = left_r ? (ptr_r + IW'(1)) : (ptr_r - IW'(1));
  assign shift_last = (ptr_adj == pos_r);
  assign out_free   = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecp_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = ecp_pkg::S_SCORE;
        end
      end
      ecp_pkg::S_SCORE: begin
        if (!usable) begin
          state_nxt = ecp_pkg::S_BEST_RD;
        end else if (fill_r == '0) begin
          state_nxt = ecp_pkg::S_INSERT;
        end else begin
          state_nxt = ecp_pkg::S_SCAN_RD;
        end
      end
      ecp_pkg::S_SCAN_RD: state_nxt = ecp_pkg::S_SCAN_CMP;
      ecp_pkg::S_SCAN_CMP: begin
        if (!scan_done) begin
          state_nxt = ecp_pkg::S_SCAN_RD;
        end else if (drop) begin
          state_nxt = ecp_pkg::S_BEST_RD;
        end else if (full) begin
          state_nxt = (k_w == CW'(1)) ? ecp_pkg::S_INSERT : ecp_pkg::S_SHIFT_RD;
        end else if (k_w < fill_r) begin
          state_nxt = ecp_pkg::S_SHIFT_RD;
        end else begin
          state_nxt = ecp_pkg::S_INSERT;
        end
      end
      ecp_pkg::S_SHIFT_RD: state_nxt = ecp_pkg::S_SHIFT_WR;
      ecp_pkg::S_SHIFT_WR: begin
        state_nxt = shift_last ? ecp_pkg::S_INSERT : ecp_pkg::S_SHIFT_RD;
      end
      ecp_pkg::S_INSERT:  state_nxt = ecp_pkg::S_BEST_RD;
      ecp_pkg::S_BEST_RD: state_nxt = ecp_pkg::S_DONE;
      ecp_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = ecp_pkg::S_IDLE;
        end
      end
      default: state_nxt = ecp_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    key_nxt       = key_r;
    db_nxt        = db_r;
    key0_nxt      = key0_r;
    dkey_nxt      = dkey_r;
    dvalid_nxt    = dvalid_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wdata         = {db_r, key_r, score};
    case (state_r)
      ecp_pkg::S_IDLE: begin
        if (in_acc) begin
          key_nxt = KEY_BITS'(in_tdata[31:0]);
          db_nxt  = in_tdata[35:32];
        end
      end
      ecp_pkg::S_SCORE: begin
        idx_nxt    = '0;
        pos_nxt    = '0;
        dvalid_nxt = 1'b0;
        dkey_nxt   = '0;
        acc_nxt    = 1'b0;
      end
      ecp_pkg::S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[IW-1:0];
      end
      ecp_pkg::S_SCAN_CMP: begin
        if (idx_r == '0) begin
          key0_nxt = rd_key;
        end
        if (!scan_done) begin
          idx_nxt = idx_inc;
        end else if (!drop) begin
          if (full) begin
            pos_nxt    = IW'(k_w - CW'(1));
            ptr_nxt    = '0;
            left_nxt   = 1'b1;
            dvalid_nxt = 1'b1;
            dkey_nxt   = (idx_r == '0) ? rd_key : key0_r;
          end else begin
            pos_nxt  = IW'(k_w);
            ptr_nxt  = IW'(fill_r);
            left_nxt = 1'b0;
          end
        end
      end
      ecp_pkg::S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_adj;
      end
      ecp_pkg::S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wdata   = rdata_r;
        ptr_nxt = ptr_adj;
      end
      ecp_pkg::S_INSERT: begin
        wr_en   = 1'b1;
        acc_nxt = 1'b1;
        if (!full) begin
          fill_nxt = fill_r + CW'(1);
        end
      end
      ecp_pkg::S_BEST_RD: begin
        rd_en   = (fill_r != '0);
        rd_addr = IW'(fill_r - CW'(1));
      end
      ecp_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[0]     = acc_r;
          out_data_nxt[4:1]   = acc_r ? 4'(pos_r) : 4'd0;
          out_data_nxt[5]     = dvalid_r;
          out_data_nxt[37:6]  = 32'(dkey_r);
          out_data_nxt[42:38] = 5'(fill_r);
          if (fill_r != '0) begin
            out_data_nxt[74:43]  = 32'(rd_key);
            out_data_nxt[78:75]  = rd_db;
            out_data_nxt[142:79] = rd_score;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecp_pkg::S_IDLE;
      policy_r    <= ecp_pkg::POL_LRU;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    ptr_r      <= ptr_nxt;
    left_r     <= left_nxt;
    key_r      <= key_nxt;
    db_r       <= db_nxt;
    key0_r     <= key0_nxt;
    dkey_r     <= dkey_nxt;
    dvalid_r   <= dvalid_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(POOL_DEPTH))
    else $error("pool fill count beyond depth");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fill_r >= $past(fill_r))
    else $error("pool fill count decreased");

  a_displace_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecp_pkg::S_DONE && dvalid_r) |-> full && acc_r)
    else $error("displacement without a full pool");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecp_pkg::S_INSERT && !full) |=> fill_r == $past(fill_r) + CW'(1))
    else $error("insert into partial pool did not grow fill");

endmodule
